>>> hdl/tss_pkg.sv
// tss_pkg: shared types and defaults for the tridiagonal system solver
// holds the datapath command set and the controller/datapath status struct
// no dependencies
`timescale 1ns / 1ps

package tss_pkg;

    localparam int MAX_ROWS_DEFAULT      = 64;
    localparam int VALUE_WIDTH_DEFAULT   = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int ROW_INDEX_W           = 6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIRST,
        OP_DIV_F,
        OP_MUL_U,
        OP_SUB_P,
        OP_MUL_R,
        OP_STORE,
        OP_READ,
        OP_MUL_X,
        OP_NUM,
        OP_DIV_X,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> hdl/tss_mul.sv
// tss_mul: shift-add fixed-point multiplier, one multiplier bit per cycle
// product magnitude truncated by the fraction bits, then saturated
// depends on nothing outside this file
`timescale 1ns / 1ps

module tss_mul #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_res
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] magn(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_hi;
    logic [W-1:0]  r_lo;
    logic [W-1:0]  r_mcand;
    logic          r_neg;
    logic [W-1:0]  r_res;

    logic [W:0]     sum;
    logic [2*W-1:0] shifted;
    logic [2*W-1:0] limit;
    logic           sat;

    always_comb begin
        sum     = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(W+1){1'b0}});
        shifted = {r_hi, r_lo} >> FRACTION_BITS;
        limit   = r_neg ? {{W{1'b0}}, VMIN} : {{W{1'b0}}, VMAX};
        sat     = shifted > limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && !r_busy && r_fin;
            r_fin  <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CW'(W);
                r_hi    <= '0;
                r_lo    <= magn(i_b);
                r_mcand <= magn(i_a);
                r_neg   <= i_a[W-1] ^ i_b[W-1];
            end else if (r_busy) begin
                r_hi  <= sum[W:1];
                r_lo  <= {sum[0], r_lo[W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else if (r_fin) begin
                if (sat) begin
                    r_res <= r_neg ? VMIN : VMAX;
                end else begin
                    r_res <= r_neg ? (~shifted[W-1:0] + 1'b1) : shifted[W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> hdl/tss_div.sv
// tss_div: restoring fixed-point divider, one quotient bit per cycle
// quotient (num << fraction bits) / den, truncated, saturated, with flag
// depends on nothing outside this file
`timescale 1ns / 1ps

module tss_div #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_num,
    input  logic [VALUE_WIDTH-1:0] i_den,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_res,
    output logic                   o_flag
);

    localparam int W  = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] magn(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [NW-1:0] r_q;
    logic [W-1:0]  r_dm;
    logic          r_neg;
    logic [W-1:0]  r_res;
    logic          r_flag;

    logic [W:0]    rem2;
    logic [W:0]    diff;
    logic          ge;
    logic [NW-1:0] limit;
    logic          sat;

    always_comb begin
        rem2  = {r_rem, r_q[NW-1]};
        diff  = rem2 - {1'b0, r_dm};
        ge    = rem2 >= {1'b0, r_dm};
        limit = r_neg ? NW'(VMIN) : NW'(VMAX);
        sat   = r_q > limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= i_start ? (i_den == '0) : (!r_busy && r_fin);
            r_fin  <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                if (i_den == '0) begin
                    r_res  <= i_num[W-1] ? VMIN : VMAX;
                    r_flag <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(NW);
                    r_rem  <= '0;
                    r_q    <= {magn(i_num), {FRACTION_BITS{1'b0}}};
                    r_dm   <= magn(i_den);
                    r_neg  <= i_num[W-1] ^ i_den[W-1];
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[W-1:0] : rem2[W-1:0];
                r_q   <= {r_q[NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else if (r_fin) begin
                r_flag <= sat;
                if (sat) begin
                    r_res <= r_neg ? VMIN : VMAX;
                end else begin
                    r_res <= r_neg ? (~r_q[W-1:0] + 1'b1) : r_q[W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_flag = r_flag;

endmodule

>>> hdl/tss_dp.sv
// tss_dp: solver datapath with row stores, multiplier, divider and output register
// executes one tss_pkg::t_cmd per cycle and reports unit status
// depends on tss_pkg, tss_mul, tss_div
`timescale 1ns / 1ps

module tss_dp #(
    parameter int MAX_ROWS      = tss_pkg::MAX_ROWS_DEFAULT,
    parameter int VALUE_WIDTH   = tss_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = tss_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tss_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(MAX_ROWS)-1:0]      i_addr,
    output tss_pkg::t_status                 o_sts,
    input  logic [VALUE_WIDTH-1:0]           i_sub_diagonal,
    input  logic [VALUE_WIDTH-1:0]           i_main_diagonal,
    input  logic [VALUE_WIDTH-1:0]           i_super_diagonal,
    input  logic [VALUE_WIDTH-1:0]           i_rhs,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tss_pkg::ROW_INDEX_W-1:0]  o_row_index,
    output logic [VALUE_WIDTH-1:0]           o_solution,
    output logic [VALUE_WIDTH-1:0]           o_reduced_rhs,
    output logic                             o_singular,
    output logic                             o_last_result
);

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sub_sat(input logic [W-1:0] p, input logic [W-1:0] q);
        logic [W:0] d;
        d = {p[W-1], p} - {q[W-1], q};
        if (d[W] != d[W-1]) begin
            return d[W] ? VMIN : VMAX;
        end
        return d[W-1:0];
    endfunction

    logic [W-1:0] r_piv_mem [MAX_ROWS];
    logic [W-1:0] r_red_mem [MAX_ROWS];
    logic [W-1:0] r_up_mem  [MAX_ROWS];

    logic [W-1:0] r_lower;
    logic [W-1:0] r_diag;
    logic [W-1:0] r_upper;
    logic [W-1:0] r_rhs;
    logic [W-1:0] r_prev_piv;
    logic [W-1:0] r_prev_up;
    logic [W-1:0] r_prev_red;
    logic [W-1:0] r_piv_new;
    logic [W-1:0] r_rd_piv;
    logic [W-1:0] r_rd_red;
    logic [W-1:0] r_rd_up;
    logic [W-1:0] r_num;
    logic [W-1:0] r_x;
    logic         r_sing;

    logic                            r_out_valid;
    logic [tss_pkg::ROW_INDEX_W-1:0] r_row_index;
    logic [W-1:0]                    r_solution;
    logic [W-1:0]                    r_reduced_rhs;
    logic                            r_singular;
    logic                            r_last_result;

    logic         mul_start;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic         mul_done;
    logic [W-1:0] mul_res;
    logic         div_start;
    logic [W-1:0] div_num;
    logic [W-1:0] div_den;
    logic         div_done;
    logic [W-1:0] div_res;
    logic         div_flag;

    logic         wr_en;
    logic [W-1:0] wr_piv;
    logic [W-1:0] wr_red;

    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_rd_up;
        mul_b     = r_x;
        div_start = 1'b0;
        div_num   = r_num;
        div_den   = r_rd_piv;
        wr_en     = 1'b0;
        wr_piv    = r_piv_new;
        wr_red    = sub_sat(r_rhs, mul_res);
        unique case (i_cmd.op)
            tss_pkg::OP_MUL_U: begin
                mul_start = 1'b1;
                mul_a     = div_res;
                mul_b     = r_prev_up;
            end
            tss_pkg::OP_MUL_R: begin
                mul_start = 1'b1;
                mul_a     = div_res;
                mul_b     = r_prev_red;
            end
            tss_pkg::OP_MUL_X: begin
                mul_start = 1'b1;
            end
            tss_pkg::OP_DIV_F: begin
                div_start = 1'b1;
                div_num   = r_lower;
                div_den   = r_prev_piv;
            end
            tss_pkg::OP_DIV_X: begin
                div_start = 1'b1;
            end
            tss_pkg::OP_FIRST: begin
                wr_en  = 1'b1;
                wr_piv = r_diag;
                wr_red = r_rhs;
            end
            tss_pkg::OP_STORE: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tss_mul #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    tss_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_res   (div_res),
        .o_flag  (div_flag)
    );

    // row stores
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_piv_mem[i_addr] <= wr_piv;
            r_red_mem[i_addr] <= wr_red;
            r_up_mem[i_addr]  <= r_upper;
        end
        if (i_cmd.op == tss_pkg::OP_READ) begin
            r_rd_piv <= r_piv_mem[i_addr];
            r_rd_red <= r_red_mem[i_addr];
            r_rd_up  <= r_up_mem[i_addr];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tss_pkg::OP_LOAD) begin
            r_lower <= i_sub_diagonal;
            r_diag  <= i_main_diagonal;
            r_upper <= i_super_diagonal;
            r_rhs   <= i_rhs;
        end
        if (i_cmd.op == tss_pkg::OP_SUB_P) begin
            r_piv_new <= sub_sat(r_diag, mul_res);
        end
        if (wr_en) begin
            r_prev_piv <= wr_piv;
            r_prev_red <= wr_red;
            r_prev_up  <= r_upper;
        end
        if (i_cmd.op == tss_pkg::OP_NUM) begin
            r_num <= i_cmd.first ? r_rd_red : sub_sat(r_rd_red, mul_res);
        end
        if (i_cmd.op == tss_pkg::OP_EMIT) begin
            r_x <= div_res;
        end
    end

    // singular flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sing      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == tss_pkg::OP_EMIT && i_cmd.last) begin
                r_sing <= 1'b0;
            end else if (div_done && div_flag) begin
                r_sing <= 1'b1;
            end
            if (i_cmd.op == tss_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tss_pkg::OP_EMIT) begin
            r_row_index   <= tss_pkg::ROW_INDEX_W'(i_addr);
            r_solution    <= div_res;
            r_reduced_rhs <= r_rd_red;
            r_singular    <= r_sing;
            r_last_result <= i_cmd.last;
        end
    end

    assign o_sts.mul_done = mul_done;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_row_index   = r_row_index;
    assign o_solution    = r_solution;
    assign o_reduced_rhs = r_reduced_rhs;
    assign o_singular    = r_singular;
    assign o_last_result = r_last_result;

endmodule

>>> hdl/tss_ctrl.sv
// tss_ctrl: solver controller, sequences elimination and back substitution
// issues tss_pkg::t_cmd to the datapath and reads tss_pkg::t_status back
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_ctrl #(
    parameter int MAX_ROWS = tss_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_last_row,
    input  tss_pkg::t_status            i_sts,
    output tss_pkg::t_cmd               o_cmd,
    output logic [$clog2(MAX_ROWS)-1:0] o_addr
);

    localparam int AW = $clog2(MAX_ROWS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_DIVF_S,
        ST_DIVF_W,
        ST_MULU_S,
        ST_MULU_W,
        ST_SUBP,
        ST_MULR_S,
        ST_MULR_W,
        ST_STORE,
        ST_READ,
        ST_MULX_S,
        ST_MULX_W,
        ST_NUM,
        ST_DIVX_S,
        ST_DIVX_W
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_idx;
    logic          r_first;
    logic          r_last;
    logic          r_emit;

    logic accept;

    assign accept     = i_in_valid && (r_state == ST_IDLE) && !r_emit;
    assign o_in_stall = (r_state != ST_IDLE) || r_emit;
    assign o_addr     = (r_state == ST_READ || r_emit) ? r_idx : r_row;

    always_comb begin
        o_cmd.op    = tss_pkg::OP_NONE;
        o_cmd.first = r_first;
        o_cmd.last  = (r_idx == '0);
        if (r_emit) begin
            if (i_sts.out_free) begin
                o_cmd.op = tss_pkg::OP_EMIT;
            end
        end else begin
            unique case (r_state)
                ST_IDLE:   o_cmd.op = accept ? tss_pkg::OP_LOAD : tss_pkg::OP_NONE;
                ST_FIRST:  o_cmd.op = tss_pkg::OP_FIRST;
                ST_DIVF_S: o_cmd.op = tss_pkg::OP_DIV_F;
                ST_MULU_S: o_cmd.op = tss_pkg::OP_MUL_U;
                ST_SUBP:   o_cmd.op = tss_pkg::OP_SUB_P;
                ST_MULR_S: o_cmd.op = tss_pkg::OP_MUL_R;
                ST_STORE:  o_cmd.op = tss_pkg::OP_STORE;
                ST_READ:   o_cmd.op = tss_pkg::OP_READ;
                ST_MULX_S: o_cmd.op = tss_pkg::OP_MUL_X;
                ST_NUM:    o_cmd.op = tss_pkg::OP_NUM;
                ST_DIVX_S: o_cmd.op = tss_pkg::OP_DIV_X;
                default:   o_cmd.op = tss_pkg::OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_idx   <= '0;
            r_first <= 1'b0;
            r_last  <= 1'b0;
            r_emit  <= 1'b0;
        end else if (r_emit) begin
            // result waits for the output register
            if (i_sts.out_free) begin
                r_emit <= 1'b0;
                if (r_idx == '0) begin
                    r_state <= ST_IDLE;
                end else begin
                    r_idx   <= r_idx - 1'b1;
                    r_first <= 1'b0;
                    r_state <= ST_READ;
                end
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_last  <= i_last_row || (r_row == AW'(MAX_ROWS - 1));
                        r_state <= (r_row == '0) ? ST_FIRST : ST_DIVF_S;
                    end
                end
                ST_FIRST, ST_STORE: begin
                    if (r_last) begin
                        r_idx   <= r_row;
                        r_row   <= '0;
                        r_first <= 1'b1;
                        r_state <= ST_READ;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIVF_S: r_state <= ST_DIVF_W;
                ST_DIVF_W: if (i_sts.div_done) r_state <= ST_MULU_S;
                ST_MULU_S: r_state <= ST_MULU_W;
                ST_MULU_W: if (i_sts.mul_done) r_state <= ST_SUBP;
                ST_SUBP:   r_state <= ST_MULR_S;
                ST_MULR_S: r_state <= ST_MULR_W;
                ST_MULR_W: if (i_sts.mul_done) r_state <= ST_STORE;
                ST_READ:   r_state <= r_first ? ST_NUM : ST_MULX_S;
                ST_MULX_S: r_state <= ST_MULX_W;
                ST_MULX_W: if (i_sts.mul_done) r_state <= ST_NUM;
                ST_NUM:    r_state <= ST_DIVX_S;
                ST_DIVX_S: r_state <= ST_DIVX_W;
                ST_DIVX_W: if (i_sts.div_done) r_emit <= 1'b1;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == tss_pkg::OP_EMIT |-> i_sts.out_free)
        else $error("emit issued while output register is held");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("controller took a row without going busy");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= AW'(MAX_ROWS - 1))
        else $error("row count beyond store depth");

    a_emit_only_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> r_state == ST_DIVX_W)
        else $error("emit pending outside back substitution");

endmodule

>>> hdl/tridiagonal_system_solver.sv
// tridiagonal_system_solver: tridiagonal linear system solver, signed fixed point
// rows enter on the input channel; solution elements leave on the output channel
// depends on tss_pkg, tss_ctrl, tss_dp
//
// input channel: one item per matrix row (sub, main, super diagonal, rhs, last_row),
// accepted when i_in_valid is high and o_in_stall is low. forward elimination runs
// on each row as it arrives; the row at store depth is taken as the last row.
// per row: the first row is stored directly; later rows run one division of
// VALUE_WIDTH+FRACTION_BITS steps and two shift-add multiplies of VALUE_WIDTH steps.
// after the last row the block back-substitutes and emits one item per row from the
// last index down to 0, last_result high on index 0. the first result needs one
// division; each later one costs one multiply and one division. a zero divisor
// ends its division without running its steps. the output register holds a
// result while i_out_stall is high and back substitution pauses until it is taken.
// the next system may enter while the final result still waits. reset (synchronous,
// active low) clears row count, singular flag and output valid; stores need no clearing.
`timescale 1ns / 1ps

module tridiagonal_system_solver #(
    parameter int MAX_ROWS      = tss_pkg::MAX_ROWS_DEFAULT,
    parameter int VALUE_WIDTH   = tss_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = tss_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [VALUE_WIDTH-1:0]          i_sub_diagonal,
    input  logic [VALUE_WIDTH-1:0]          i_main_diagonal,
    input  logic [VALUE_WIDTH-1:0]          i_super_diagonal,
    input  logic [VALUE_WIDTH-1:0]          i_rhs,
    input  logic                            i_last_row,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tss_pkg::ROW_INDEX_W-1:0] o_row_index,
    output logic [VALUE_WIDTH-1:0]          o_solution,
    output logic [VALUE_WIDTH-1:0]          o_reduced_rhs,
    output logic                            o_singular,
    output logic                            o_last_result
);

    tss_pkg::t_cmd                cmd;
    tss_pkg::t_status             sts;
    logic [$clog2(MAX_ROWS)-1:0]  addr;

    tss_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_last_row (i_last_row),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    tss_dp #(
        .MAX_ROWS      (MAX_ROWS),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_addr           (addr),
        .o_sts            (sts),
        .i_sub_diagonal   (i_sub_diagonal),
        .i_main_diagonal  (i_main_diagonal),
        .i_super_diagonal (i_super_diagonal),
        .i_rhs            (i_rhs),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_row_index      (o_row_index),
        .o_solution       (o_solution),
        .o_reduced_rhs    (o_reduced_rhs),
        .o_singular       (o_singular),
        .o_last_result    (o_last_result)
    );

endmodule
